@@ src/ray_plane_intersection_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef RAY_PLANE_INTERSECTION_MACROS_SVH
`define RAY_PLANE_INTERSECTION_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define RPI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpi: same-cycle check failed");

// Next-cycle implication, masked while reset is high.
`define RPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpi: next-cycle check failed");

`endif

@@ src/rpi_pkg.sv @@
`timescale 1ns / 1ps
package rpi_pkg;

   // operand slice handled by one multiplier stage
   localparam int MUL_CHUNK = 32;

   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SOURCE_X = 2'd0,
      CSR_SOURCE_Y = 2'd1,
      CSR_SOURCE_Z = 2'd2
   } csr_index_type;

endpackage

@@ src/ray_plane_intersection.sv @@
`timescale 1ns / 1ps
// Ray / plane intersection for shadow projection. Each transfer on req_ brings
// a point P and three plane points A, B, C; with the source S set through the
// csr_ port, the block returns H = S - (n.(S-A) / n.(P-S)) * (P-S), where
// n = (B-A) x (C-A), every product exact and the quotient rounded to nearest
// with ties away from zero, so H does not depend on the fraction width. A hit
// coordinate out of range is clamped and is_saturated set; when n.(P-S) is
// zero (parallel ray, degenerate plane, or P equal to S) H is S and
// is_parallel is set. Throughput is one transfer per clock while the output
// skid register is empty. Each multiplier is ceil(operand a width / 32)
// stages deep, and the long divider (one quotient bit per stage) makes up
// most of the pipeline. Write the source only while no transfer is in
// flight.
module ray_plane_intersection
   import rpi_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]                csr_index,
   input  logic [COORD_WIDTH-1:0]                    csr_wdata,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // point_x/y/z, plane_a_x/y/z, plane_b_x/y/z, plane_c_x/y/z, from bit 0 up
   input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // hit_x, hit_y, hit_z, from bit 0 up
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]        rsp_tdata,
   // is_parallel, is_saturated, from bit 0 up
   output logic [1:0]                                rsp_tuser
);

   localparam int W        = COORD_WIDTH;
   localparam int OUT_BITS = ((3 * W + 7) / 8) * 8;
   localparam int DIFF_W   = W + 1;              // coordinate differences
   localparam int PROD1_W  = 2 * DIFF_W;         // edge products
   localparam int NRM_W    = PROD1_W + 1;        // normal components
   localparam int PROD2_W  = NRM_W + DIFF_W;     // normal times difference
   localparam int SUM_W    = PROD2_W + 2;        // num and den
   localparam int PROD3_W  = SUM_W + DIFF_W;     // num times ray
   localparam int QUO_W    = W + 2;              // quotient bits kept
   localparam int HIT_W    = QUO_W + 3;

   localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

   // pipeline advances unless the output skid register is occupied
   logic en;

   // ---------------- source registers ----------------
   logic signed [W-1:0] source_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff[0] <= '0;
         source_ff[1] <= '0;
         source_ff[2] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SOURCE_X: source_ff[0] <= csr_wdata;
            CSR_SOURCE_Y: source_ff[1] <= csr_wdata;
            CSR_SOURCE_Z: source_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- stage A: differences ----------------
   logic signed [W-1:0] pt [3];
   logic signed [W-1:0] pa [3];
   logic signed [W-1:0] pb [3];
   logic signed [W-1:0] pc [3];

   logic [2:0][DIFF_W-1:0] ray_in, e1_in, e2_in, w_in;
   logic [2:0][DIFF_W-1:0] ray_a_ff, e1_a_ff, e2_a_ff, w_a_ff;
   logic                   a_vld_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pt[k] = req_tdata[k*W +: W];
         pa[k] = req_tdata[(3+k)*W +: W];
         pb[k] = req_tdata[(6+k)*W +: W];
         pc[k] = req_tdata[(9+k)*W +: W];
         ray_in[k] = DIFF_W'(pt[k]) - DIFF_W'(source_ff[k]);
         e1_in[k]  = DIFF_W'(pb[k]) - DIFF_W'(pa[k]);
         e2_in[k]  = DIFF_W'(pc[k]) - DIFF_W'(pa[k]);
         w_in[k]   = DIFF_W'(source_ff[k]) - DIFF_W'(pa[k]);
      end
   end

   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_tvalid;
      end
      if (en) begin
         ray_a_ff <= ray_in;
         e1_a_ff  <= e1_in;
         e2_a_ff  <= e2_in;
         w_a_ff   <= w_in;
      end
   end

   // ---------------- stage B: edge cross products ----------------
   logic [5:0][DIFF_W-1:0]  m1_a, m1_b;
   logic [5:0][PROD1_W-1:0] m1_p;
   logic                    m1_vld;
   logic [2:0][DIFF_W-1:0]  ray_m1, w_m1;

   // lane k: e1[u]*e2[v], lane 3+k: e1[v]*e2[u], with u, v the next axes
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         m1_a[k]   = e1_a_ff[(k+1)%3];
         m1_b[k]   = e2_a_ff[(k+2)%3];
         m1_a[3+k] = e1_a_ff[(k+2)%3];
         m1_b[3+k] = e2_a_ff[(k+1)%3];
      end
   end

   rpi_mul #(
      .LANES     (6),
      .A_WIDTH   (DIFF_W),
      .B_WIDTH   (DIFF_W),
      .TAG_WIDTH (6 * DIFF_W)
   ) u_mul_edge (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (a_vld_ff),
      .a       (m1_a),
      .b       (m1_b),
      .tag_in  ({ray_a_ff, w_a_ff}),
      .out_vld (m1_vld),
      .p       (m1_p),
      .tag_out ({ray_m1, w_m1})
   );

   // ---------------- stage C: normal ----------------
   logic [2:0][NRM_W-1:0]  n_in, n_c_ff;
   logic [2:0][DIFF_W-1:0] ray_c_ff, w_c_ff;
   logic                   c_vld_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         n_in[k] = NRM_W'($signed(m1_p[k])) - NRM_W'($signed(m1_p[3+k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= m1_vld;
      end
      if (en) begin
         n_c_ff   <= n_in;
         ray_c_ff <= ray_m1;
         w_c_ff   <= w_m1;
      end
   end

   // ---------------- stage D: dot product terms ----------------
   logic [5:0][NRM_W-1:0]   m2_a;
   logic [5:0][DIFF_W-1:0]  m2_b;
   logic [5:0][PROD2_W-1:0] m2_p;
   logic                    m2_vld;
   logic [2:0][DIFF_W-1:0]  ray_m2;

   // lanes 0..2 feed num (n.w), lanes 3..5 feed den (n.ray)
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         m2_a[k]   = n_c_ff[k];
         m2_b[k]   = w_c_ff[k];
         m2_a[3+k] = n_c_ff[k];
         m2_b[3+k] = ray_c_ff[k];
      end
   end

   rpi_mul #(
      .LANES     (6),
      .A_WIDTH   (NRM_W),
      .B_WIDTH   (DIFF_W),
      .TAG_WIDTH (3 * DIFF_W)
   ) u_mul_dot (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (c_vld_ff),
      .a       (m2_a),
      .b       (m2_b),
      .tag_in  (ray_c_ff),
      .out_vld (m2_vld),
      .p       (m2_p),
      .tag_out (ray_m2)
   );

   // ---------------- stage E: sums, two adds deep ----------------
   logic [SUM_W-1:0]       num01_ff, num2_ff, den01_ff, den2_ff;
   logic [2:0][DIFF_W-1:0] ray_e1_ff;
   logic                   e1_vld_ff;
   logic [SUM_W-1:0]       num_ff, den_ff;
   logic [2:0][DIFF_W-1:0] ray_e2_ff;
   logic                   e2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_vld_ff <= 1'b0;
         e2_vld_ff <= 1'b0;
      end else if (en) begin
         e1_vld_ff <= m2_vld;
         e2_vld_ff <= e1_vld_ff;
      end
      if (en) begin
         num01_ff  <= SUM_W'($signed(m2_p[0])) + SUM_W'($signed(m2_p[1]));
         num2_ff   <= SUM_W'($signed(m2_p[2]));
         den01_ff  <= SUM_W'($signed(m2_p[3])) + SUM_W'($signed(m2_p[4]));
         den2_ff   <= SUM_W'($signed(m2_p[5]));
         ray_e1_ff <= ray_m2;
         num_ff    <= num01_ff + num2_ff;
         den_ff    <= den01_ff + den2_ff;
         ray_e2_ff <= ray_e1_ff;
      end
   end

   // ---------------- stage F: num times ray ----------------
   logic [2:0][SUM_W-1:0]   m3_a;
   logic [2:0][PROD3_W-1:0] m3_p;
   logic                    m3_vld;
   logic [SUM_W-1:0]        den_m3;

   assign m3_a = {3{num_ff}};

   rpi_mul #(
      .LANES     (3),
      .A_WIDTH   (SUM_W),
      .B_WIDTH   (DIFF_W),
      .TAG_WIDTH (SUM_W)
   ) u_mul_scale (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (e2_vld_ff),
      .a       (m3_a),
      .b       (ray_e2_ff),
      .tag_in  (den_ff),
      .out_vld (m3_vld),
      .p       (m3_p),
      .tag_out (den_m3)
   );

   // ---------------- stage M: magnitudes and signs ----------------
   logic [2:0][PROD3_W-1:0] pmag_in, pmag_m_ff;
   logic [2:0]              neg_in, neg_m_ff;
   logic [SUM_W-1:0]        dmag_m_ff;
   logic                    par_m_ff;
   logic                    m_vld_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg_in[k]  = m3_p[k][PROD3_W-1] ^ den_m3[SUM_W-1];
         pmag_in[k] = m3_p[k][PROD3_W-1] ? -m3_p[k] : m3_p[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (en) begin
         m_vld_ff <= m3_vld;
      end
      if (en) begin
         pmag_m_ff <= pmag_in;
         neg_m_ff  <= neg_in;
         dmag_m_ff <= den_m3[SUM_W-1] ? -den_m3 : den_m3;
         par_m_ff  <= den_m3 == '0;
      end
   end

   // ---------------- divider ----------------
   logic [2:0][QUO_W:0] dv_q;
   logic [2:0]          dv_big;
   logic [2:0]          dv_neg;
   logic                dv_par;
   logic                dv_vld;

   rpi_div #(
      .LANES     (3),
      .N_WIDTH   (PROD3_W),
      .D_WIDTH   (SUM_W),
      .Q_WIDTH   (QUO_W),
      .TAG_WIDTH (4)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (m_vld_ff),
      .num     (pmag_m_ff),
      .den     (dmag_m_ff),
      .tag_in  ({par_m_ff, neg_m_ff}),
      .out_vld (dv_vld),
      .q       (dv_q),
      .big     (dv_big),
      .tag_out ({dv_par, dv_neg})
   );

   // ---------------- stage H: hit = S - q, clamp ----------------
   logic signed [HIT_W-1:0] qs     [3];
   logic signed [HIT_W-1:0] h_wide [3];
   logic [2:0][W-1:0]       hit_in, hit_h_ff;
   logic [2:0]              sat_lane;
   logic                    par_h_ff, sat_h_ff;
   logic                    h_vld_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         qs[k]     = dv_neg[k] ? -HIT_W'(dv_q[k]) : HIT_W'(dv_q[k]);
         h_wide[k] = HIT_W'(source_ff[k]) - qs[k];
         sat_lane[k] = 1'b1;
         if (dv_big[k]) begin
            // quotient past the kept bits: always out of range, opposite sign
            hit_in[k] = dv_neg[k] ? CMAX : CMIN;
         end else if (h_wide[k] > HIT_W'(CMAX)) begin
            hit_in[k] = CMAX;
         end else if (h_wide[k] < HIT_W'(CMIN)) begin
            hit_in[k] = CMIN;
         end else begin
            hit_in[k]   = h_wide[k][W-1:0];
            sat_lane[k] = 1'b0;
         end
         if (dv_par) begin
            hit_in[k]   = source_ff[k];
            sat_lane[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (en) begin
         h_vld_ff <= dv_vld;
      end
      if (en) begin
         hit_h_ff <= hit_in;
         par_h_ff <= dv_par;
         sat_h_ff <= |sat_lane;
      end
   end

   // ---------------- output register with skid ----------------
   logic              out_vld_ff, skid_vld_ff;
   logic [2:0][W-1:0] out_hit_ff, skid_hit_ff;
   logic [1:0]        out_flag_ff, skid_flag_ff;
   logic              take;

   assign take = out_vld_ff && rsp_tready;
   assign en   = !skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (take) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (!out_vld_ff || take) begin
         out_vld_ff <= h_vld_ff;
      end else if (h_vld_ff) begin
         skid_vld_ff <= 1'b1;
      end

      if (skid_vld_ff) begin
         if (take) begin
            out_hit_ff  <= skid_hit_ff;
            out_flag_ff <= skid_flag_ff;
         end
      end else if (!out_vld_ff || take) begin
         out_hit_ff  <= hit_h_ff;
         out_flag_ff <= {sat_h_ff, par_h_ff};
      end else begin
         skid_hit_ff  <= hit_h_ff;
         skid_flag_ff <= {sat_h_ff, par_h_ff};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = OUT_BITS'(out_hit_ff);
   assign rsp_tuser  = out_flag_ff;

endmodule

@@ src/rpi_mul.sv @@
`timescale 1ns / 1ps
// Signed multiplier, LANES wide, one MUL_CHUNK slice of operand a per stage.
module rpi_mul
   import rpi_pkg::*;
#(
   parameter int LANES     = 1,
   parameter int A_WIDTH   = 33,
   parameter int B_WIDTH   = 33,
   parameter int TAG_WIDTH = 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_vld,
   input  logic [LANES-1:0][A_WIDTH-1:0]          a,
   input  logic [LANES-1:0][B_WIDTH-1:0]          b,
   input  logic [TAG_WIDTH-1:0]                   tag_in,
   output logic                                   out_vld,
   output logic [LANES-1:0][A_WIDTH+B_WIDTH-1:0]  p,
   output logic [TAG_WIDTH-1:0]                   tag_out
);

   localparam int P_WIDTH = A_WIDTH + B_WIDTH;
   localparam int STAGES  = (A_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;

   logic                              vld_src [STAGES];
   logic [LANES-1:0][A_WIDTH-1:0]     a_src   [STAGES];
   logic [LANES-1:0][B_WIDTH-1:0]     b_src   [STAGES];
   logic [LANES-1:0][P_WIDTH-1:0]     acc_src [STAGES];
   logic [TAG_WIDTH-1:0]              tag_src [STAGES];
   logic [LANES-1:0][P_WIDTH-1:0]     acc_in  [STAGES];

   logic                              vld_ff  [STAGES];
   logic [LANES-1:0][A_WIDTH-1:0]     a_ff    [STAGES];
   logic [LANES-1:0][B_WIDTH-1:0]     b_ff    [STAGES];
   logic [LANES-1:0][P_WIDTH-1:0]     acc_ff  [STAGES];
   logic [TAG_WIDTH-1:0]              tag_ff  [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int LO = s * MUL_CHUNK;
      localparam int HI = (s == STAGES - 1) ? A_WIDTH : LO + MUL_CHUNK;

      if (s == 0) begin : g_first
         assign vld_src[s] = in_vld;
         assign a_src[s]   = a;
         assign b_src[s]   = b;
         assign acc_src[s] = '0;
         assign tag_src[s] = tag_in;
      end else begin : g_next
         assign vld_src[s] = vld_ff[s-1];
         assign a_src[s]   = a_ff[s-1];
         assign b_src[s]   = b_ff[s-1];
         assign acc_src[s] = acc_ff[s-1];
         assign tag_src[s] = tag_ff[s-1];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic signed [HI-LO:0]      chunk;
         logic signed [B_WIDTH-1:0]  mulb;
         logic signed [P_WIDTH-1:0]  pp;

         // top slice carries the sign, lower slices are unsigned
         if (s == STAGES - 1) begin : g_top
            assign chunk = {a_src[s][l][HI-1], a_src[s][l][HI-1:LO]};
         end else begin : g_low
            assign chunk = {1'b0, a_src[s][l][HI-1:LO]};
         end
         assign mulb = b_src[s][l];
         assign pp   = chunk * mulb;
         assign acc_in[s][l] = acc_src[s][l] + P_WIDTH'(pp <<< LO);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src[s];
         end
         if (en) begin
            a_ff[s]   <= a_src[s];
            b_ff[s]   <= b_src[s];
            acc_ff[s] <= acc_in[s];
            tag_ff[s] <= tag_src[s];
         end
      end
   end

   assign out_vld = vld_ff[STAGES-1];
   assign p       = acc_ff[STAGES-1];
   assign tag_out = tag_ff[STAGES-1];

endmodule

@@ src/rpi_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage, rounded to nearest (ties up
// on magnitudes). Only the low Q_WIDTH quotient bits are formed; big flags a
// quotient of 2**Q_WIDTH or more.
module rpi_div #(
   parameter int LANES     = 3,
   parameter int N_WIDTH   = 135,
   parameter int D_WIDTH   = 102,
   parameter int Q_WIDTH   = 34,
   parameter int TAG_WIDTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_vld,
   input  logic [LANES-1:0][N_WIDTH-1:0]     num,
   input  logic [D_WIDTH-1:0]                den,
   input  logic [TAG_WIDTH-1:0]              tag_in,
   output logic                              out_vld,
   output logic [LANES-1:0][Q_WIDTH:0]       q,
   output logic [LANES-1:0]                  big,
   output logic [TAG_WIDTH-1:0]              tag_out
);

   logic                           vld_ff  [Q_WIDTH+1];
   logic [LANES-1:0][D_WIDTH-1:0]  rem_ff  [Q_WIDTH+1];
   logic [LANES-1:0][D_WIDTH-1:0]  rem_in  [Q_WIDTH+1];
   logic [LANES-1:0][Q_WIDTH-1:0]  lo_ff   [Q_WIDTH+1];
   logic [LANES-1:0][Q_WIDTH-1:0]  lo_in   [Q_WIDTH+1];
   logic [LANES-1:0][Q_WIDTH-1:0]  quo_ff  [Q_WIDTH+1];
   logic [LANES-1:0][Q_WIDTH-1:0]  quo_in  [Q_WIDTH+1];
   logic [LANES-1:0]               big_ff  [Q_WIDTH+1];
   logic [LANES-1:0]               big_in;
   logic [D_WIDTH-1:0]             den_ff  [Q_WIDTH+1];
   logic [TAG_WIDTH-1:0]           tag_ff  [Q_WIDTH+1];

   logic                           rnd_vld_ff;
   logic [LANES-1:0][Q_WIDTH:0]    rnd_q_ff;
   logic [LANES-1:0][Q_WIDTH:0]    rnd_q_in;
   logic [LANES-1:0]               rnd_big_ff;
   logic [TAG_WIDTH-1:0]           rnd_tag_ff;

   // stage 0: split numerator, flag overflow of the kept quotient bits
   for (genvar l = 0; l < LANES; l++) begin : g_init
      assign rem_in[0][l] = D_WIDTH'(num[l] >> Q_WIDTH);
      assign lo_in[0][l]  = num[l][Q_WIDTH-1:0];
      assign quo_in[0][l] = '0;
      assign big_in[l]    = (num[l] >> Q_WIDTH) >= N_WIDTH'(den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
      if (en) begin
         rem_ff[0] <= rem_in[0];
         lo_ff[0]  <= lo_in[0];
         quo_ff[0] <= quo_in[0];
         big_ff[0] <= big_in;
         den_ff[0] <= den;
         tag_ff[0] <= tag_in;
      end
   end

   for (genvar j = 1; j <= Q_WIDTH; j++) begin : g_bit
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [D_WIDTH:0] trial;
         logic [D_WIDTH:0] diff;
         logic             ge;

         assign trial = {rem_ff[j-1][l], lo_ff[j-1][l][Q_WIDTH-1]};
         assign diff  = trial - {1'b0, den_ff[j-1]};
         assign ge    = trial >= {1'b0, den_ff[j-1]};
         assign rem_in[j][l] = ge ? diff[D_WIDTH-1:0] : trial[D_WIDTH-1:0];
         assign lo_in[j][l]  = {lo_ff[j-1][l][Q_WIDTH-2:0], 1'b0};
         assign quo_in[j][l] = {quo_ff[j-1][l][Q_WIDTH-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_ff[j-1];
         end
         if (en) begin
            rem_ff[j] <= rem_in[j];
            lo_ff[j]  <= lo_in[j];
            quo_ff[j] <= quo_in[j];
            big_ff[j] <= big_ff[j-1];
            den_ff[j] <= den_ff[j-1];
            tag_ff[j] <= tag_ff[j-1];
         end
      end
   end

   // round: remainder at least half the divisor bumps the quotient
   for (genvar l = 0; l < LANES; l++) begin : g_round
      logic up;
      assign up = {rem_ff[Q_WIDTH][l], 1'b0} >= {1'b0, den_ff[Q_WIDTH]};
      assign rnd_q_in[l] = {1'b0, quo_ff[Q_WIDTH][l]} + (Q_WIDTH+1)'(up);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_vld_ff <= 1'b0;
      end else if (en) begin
         rnd_vld_ff <= vld_ff[Q_WIDTH];
      end
      if (en) begin
         rnd_q_ff   <= rnd_q_in;
         rnd_big_ff <= big_ff[Q_WIDTH];
         rnd_tag_ff <= tag_ff[Q_WIDTH];
      end
   end

   assign out_vld = rnd_vld_ff;
   assign q       = rnd_q_ff;
   assign big     = rnd_big_ff;
   assign tag_out = rnd_tag_ff;

endmodule

@@ src/rpi_checker.sv @@
`timescale 1ns / 1ps
`include "ray_plane_intersection_macros.svh"
module rpi_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [((3*COORD_WIDTH+7)/8)*8-1:0]   rsp_tdata,
   input logic [1:0]                           rsp_tuser
);

   // stalled result holds
   `RPI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a parallel ray returns the source, never a clamped value
   `RPI_ASSERT_IMPLY(a_par_not_sat, clock, reset, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]))

   // input backpressure only after a refused output transfer
   `RPI_ASSERT_IMPLY(a_bp_cause, clock, reset, !req_tready, rsp_tvalid && !$past(rsp_tready))

endmodule

bind ray_plane_intersection rpi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rpi_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ray_plane_intersection.
// Stimulus tasks push items through a shared sender; a monitor on the
// rsp_ side pops the matching expected hit and compares field by field.
module tb_top;
   import rpi_pkg::*;

   localparam int CW        = 32;
   localparam int REQ_W     = 12 * CW;
   localparam int RSP_W     = 3 * CW;
   // pipeline depth of the block, plus slack
   localparam int DRAIN_CYC = 70;
   localparam logic signed [255:0] COORD_MAX = 256'sh7FFFFFFF;
   localparam logic signed [255:0] COORD_MIN = -256'sh80000000;

   typedef struct packed {
      logic [CW-1:0] hit_x;
      logic [CW-1:0] hit_y;
      logic [CW-1:0] hit_z;
      logic          is_parallel;
      logic          is_saturated;
   } hit_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   csr_index_type     csr_index;
   logic [CW-1:0]     csr_wdata;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic [1:0]        rsp_tuser;

   // bench copy of the source registers
   logic [CW-1:0]     source_pos [3];
   hit_type           pending_hits [$];
   int                fail_count;
   bit                send_no_gap;
   bit                recv_no_stall;
   int                stall_left;

   ray_plane_intersection #(.COORD_WIDTH(CW)) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // exact intersection: wide signed math, quotient rounded half away from zero
   function automatic hit_type predict_hit(input logic [REQ_W-1:0] d);
      logic signed [255:0] s [3], p [3], a [3], b [3], c [3];
      logic signed [255:0] ray [3], e1 [3], e2 [3], w [3], nrm [3];
      logic signed [255:0] num, den, prod, pmag, dmag, qmag, rmag, q, h;
      logic [CW-1:0]       hv [3];
      hit_type             r;
      bit                  sat;
      sat = 1'b0;
      for (int k = 0; k < 3; k++) begin
         s[k] = $signed(source_pos[k]);
         p[k] = $signed(d[CW*k +: CW]);
         a[k] = $signed(d[CW*(3+k) +: CW]);
         b[k] = $signed(d[CW*(6+k) +: CW]);
         c[k] = $signed(d[CW*(9+k) +: CW]);
         ray[k] = p[k] - s[k];
         e1[k]  = b[k] - a[k];
         e2[k]  = c[k] - a[k];
         w[k]   = s[k] - a[k];
      end
      for (int k = 0; k < 3; k++)
         nrm[k] = e1[(k+1)%3] * e2[(k+2)%3] - e1[(k+2)%3] * e2[(k+1)%3];
      num = nrm[0]*w[0] + nrm[1]*w[1] + nrm[2]*w[2];
      den = nrm[0]*ray[0] + nrm[1]*ray[1] + nrm[2]*ray[2];
      if (den == 0) begin
         r.hit_x = source_pos[0];
         r.hit_y = source_pos[1];
         r.hit_z = source_pos[2];
         r.is_parallel  = 1'b1;
         r.is_saturated = 1'b0;
         return r;
      end
      dmag = (den < 0) ? -den : den;
      for (int k = 0; k < 3; k++) begin
         prod = num * ray[k];
         pmag = (prod < 0) ? -prod : prod;
         qmag = pmag / dmag;
         rmag = pmag - qmag * dmag;
         if (2 * rmag >= dmag) qmag = qmag + 1;
         q = ((prod < 0) != (den < 0)) ? -qmag : qmag;
         h = s[k] - q;
         if (h > COORD_MAX) begin
            h = COORD_MAX;
            sat = 1'b1;
         end else if (h < COORD_MIN) begin
            h = COORD_MIN;
            sat = 1'b1;
         end
         hv[k] = h[CW-1:0];
      end
      r.hit_x = hv[0];
      r.hit_y = hv[1];
      r.hit_z = hv[2];
      r.is_parallel  = 1'b0;
      r.is_saturated = sat;
      return r;
   endfunction

   // fields listed P, A, B, C; P lands in the low bits
   function automatic logic [REQ_W-1:0] make_item(
      input logic [CW-1:0] px, py, pz, ax, ay, az,
      input logic [CW-1:0] bx, by, bz, cx, cy, cz);
      return {cz, cy, cx, bz, by, bx, az, ay, ax, pz, py, px};
   endfunction

   // one req_ transfer; tvalid stays up when the next item follows with no gap
   task automatic send_item(input logic [REQ_W-1:0] d);
      int gap;
      gap = send_no_gap ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      pending_hits.push_back(predict_hit(d));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic write_source(input csr_index_type idx, input logic [CW-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      source_pos[idx] = val;
   endtask

   task automatic set_source(input logic [CW-1:0] sx, sy, sz);
      wait_drained();
      write_source(CSR_SOURCE_X, sx);
      write_source(CSR_SOURCE_Y, sy);
      write_source(CSR_SOURCE_Z, sz);
   endtask

   // coordinate draw: full range, small, or one of the corner values
   function automatic logic [CW-1:0] pick_coord(input int mode);
      logic [CW-1:0] corners [5];
      corners = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF};
      case (mode)
         0:       return $urandom();
         1:       return corners[$urandom_range(0, 4)];
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   task automatic send_random_item();
      logic [CW-1:0] f [12];
      int sel, mode;
      sel = $urandom_range(0, 9);
      mode = (sel < 2) ? 0 : (sel == 9) ? 1 : 2;
      for (int i = 0; i < 12; i++) f[i] = pick_coord(mode);
      // ray lying in the plane direction: C - A = P - S gives a zero denominator
      if (sel == 7 || sel == 8)
         for (int k = 0; k < 3; k++)
            f[9+k] = f[3+k] + f[k] - source_pos[k];
      send_item(make_item(f[0], f[1], f[2], f[3], f[4], f[5],
                          f[6], f[7], f[8], f[9], f[10], f[11]));
   endtask

   // result monitor and receiver stall pattern
   always @(posedge clock) begin
      hit_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.hit_x = rsp_tdata[0 +: CW];
            got.hit_y = rsp_tdata[CW +: CW];
            got.hit_z = rsp_tdata[2*CW +: CW];
            got.is_parallel  = rsp_tuser[0];
            got.is_saturated = rsp_tuser[1];
            if (pending_hits.size() == 0) begin
               $error("unexpected rsp transfer: hit %h %h %h", got.hit_x, got.hit_y,
                      got.hit_z);
               fail_count++;
            end else begin
               want = pending_hits.pop_front();
               if (got.hit_x !== want.hit_x) begin
                  $error("hit_x exp %h got %h", want.hit_x, got.hit_x);
                  fail_count++;
               end
               if (got.hit_y !== want.hit_y) begin
                  $error("hit_y exp %h got %h", want.hit_y, got.hit_y);
                  fail_count++;
               end
               if (got.hit_z !== want.hit_z) begin
                  $error("hit_z exp %h got %h", want.hit_z, got.hit_z);
                  fail_count++;
               end
               if (got.is_parallel !== want.is_parallel) begin
                  $error("is_parallel exp %b got %b", want.is_parallel, got.is_parallel);
                  fail_count++;
               end
               if (got.is_saturated !== want.is_saturated) begin
                  $error("is_saturated exp %b got %b", want.is_saturated,
                         got.is_saturated);
                  fail_count++;
               end
            end
            stall_left = recv_no_stall ? 0 : $urandom_range(0, 3);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   localparam logic [CW-1:0] ONE  = 32'h0001_0000;
   localparam logic [CW-1:0] TWO  = 32'h0002_0000;
   localparam logic [CW-1:0] MAXV = 32'h7FFF_FFFF;
   localparam logic [CW-1:0] MINV = 32'h8000_0000;

   // hand-picked cases, run first with the source at the origin
   task automatic test_directed();
      send_item('0);                                                  // all zero
      send_item(make_item(0, 0, ONE, 0, 0, TWO, ONE, 0, TWO, 0, ONE, TWO));
      send_item(make_item(ONE, ONE, ONE, 0, 0, TWO, ONE, 0, TWO, 0, ONE, TWO));
      send_item(make_item(0, 0, 0, 0, 0, TWO, ONE, 0, TWO, 0, ONE, TWO)); // P at S
      send_item(make_item(0, 0, ONE, 5, 6, 7, 5, 6, 7, 0, ONE, TWO));     // A equals B
      send_item(make_item(ONE, 0, 0, 0, 0, TWO, ONE, 0, TWO, 0, ONE, TWO)); // parallel
      send_item(make_item(MAXV, 0, 1, 0, 0, MAXV, ONE, 0, MAXV, 0, ONE, MAXV));
      send_item(make_item(MINV, 0, 1, 0, 0, MAXV, ONE, 0, MAXV, 0, ONE, MAXV));
      send_item(make_item(3, -5, 7, 0, 0, 10, 3, 0, 10, 0, 3, 10));     // rounding
      send_item({12{MAXV}});
      send_item({12{MINV}});
      send_item({6{MINV, MAXV}});
      send_item({6{MAXV, MINV}});
      send_item(make_item(1, 1, 1, MINV, 0, 0, 0, MAXV, 0, 0, 0, MINV));
      send_item(make_item(MAXV, MINV, MAXV, 1, 2, 3, MINV, 5, MAXV, 7, MINV, 9));
   endtask

   task automatic test_random(input int count);
      repeat (count) send_random_item();
   endtask

   // back-to-back on both sides, then a full drain before continuing
   task automatic test_full_rate(input int count);
      send_no_gap   = 1'b1;
      recv_no_stall = 1'b1;
      test_random(count);
      wait_drained();
      send_no_gap   = 1'b0;
      recv_no_stall = 1'b0;
   endtask

   task automatic test_source_settings();
      set_source(MAXV, MINV, MAXV);
      test_directed();
      test_random(250);
      set_source(MINV, MAXV, MINV);
      test_random(250);
      set_source(ONE, -TWO, 32'h0003_8000);
      test_random(300);
      set_source($urandom(), $urandom(), $urandom());
      test_random(150);
      set_source(0, 0, 0);
      test_random(100);
   endtask

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_SOURCE_X;
      csr_wdata     = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      fail_count    = 0;
      send_no_gap   = 1'b0;
      recv_no_stall = 1'b0;
      stall_left    = 0;
      for (int k = 0; k < 3; k++) source_pos[k] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(400);
      test_full_rate(200);
      test_source_settings();
      test_random(150);

      wait_drained();
      if (fail_count == 0)
         $display("[ray_plane_intersection] OK");
      else
         $display("[ray_plane_intersection] ERROR");
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #(12 * 400_000);
      $display("[ray_plane_intersection] ERROR");
      $finish;
   end

endmodule
